>>> rtl/core/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

  localparam int unsigned PermDepth = 256;
  localparam int unsigned ByteW     = 8;
  localparam logic [ByteW-1:0] LastIdx = 8'hFF;

  localparam logic ActKey  = 1'b0;
  localparam logic ActData = 1'b1;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_P_J   = 9'b000000010,
    ST_P_WI  = 9'b000000100,
    ST_P_WJ  = 9'b000001000,
    ST_P_OUT = 9'b000010000,
    ST_K_RD  = 9'b000100000,
    ST_K_ACC = 9'b001000000,
    ST_K_W1  = 9'b010000000,
    ST_K_W2  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic  clr;
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } perm_req_t;

endpackage

`default_nettype wire

>>> rtl/core/rc4_stream_cipher.sv
// RC4 stream cipher engine.
// Input channel (in_valid_i/in_ready_o) carries one item: action_i selects a
// key byte (0) or a data byte (1), in_byte_i is the byte, key_end_i flags the
// last key byte. Key bytes beyond KEY_DEPTH are dropped; a flagged key byte
// still starts the key schedule over the stored bytes.
// Output channel (out_valid_o/out_ready_i) returns one item per data item:
// stream_byte_o is the keystream byte, out_byte_o is in_byte_i XOR keystream.
// Key items return nothing.
// A plain key byte is stored on acceptance and the engine stays in idle. A
// data item is taken only in idle, so no new item is accepted until the last
// one has been loaded into the output register; its steps are the dependent
// reads of S[i] and S[j], the write-backs of S[i] and S[j] (the final lookup
// is issued with the second write), the lookup result, and the return to idle.
// The key schedule reads, mixes and swaps every entry; no input is taken meanwhile.
// Reset leaves the permutation at the identity and both indexes and the key
// count at zero; no clearing pass is needed. If the receiver stalls, the
// result is held in the output register; the next item is still accepted
// and waits for the register before it completes.
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 256
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  wire  action_i,
  input  wire  [7:0] in_byte_i,
  input  wire  key_end_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [7:0] stream_byte_o
);

  localparam int unsigned CntW = $clog2(KEY_DEPTH + 1);
  localparam int unsigned KeyW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  state_e          state_q, state_d;
  byte_t           i_q, i_d, j_q, j_d;
  byte_t           si_q, si_d, sj_q, sj_d;
  byte_t           byte_q, byte_d;
  byte_t           k_q, k_d, acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d, len_q, len_d, cnt_new;
  logic [KeyW-1:0] kidx_q, kidx_d;
  logic            key_room;
  logic            key_we;
  perm_req_t       perm_req;
  byte_t           perm_rdata, key_rdata;
  byte_t           t_idx, ks;
  logic            out_valid_q, out_valid_d, out_load;
  byte_t           out_byte_q, stream_byte_q;

  rc4_perm_mem u_perm (
    .clk_i,
    .rst_ni,
    .req_i   (perm_req),
    .rdata_o (perm_rdata)
  );

  rc4_key_mem #(
    .Depth (KEY_DEPTH),
    .AddrW (KeyW)
  ) u_key (
    .clk_i,
    .we_i    (key_we),
    .waddr_i (cnt_q[KeyW-1:0]),
    .wdata_i (in_byte_i),
    .raddr_i (kidx_q),
    .rdata_o (key_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign key_room   = (cnt_q < CntW'(KEY_DEPTH));
  assign cnt_new    = key_room ? cnt_q + CntW'(1) : cnt_q;
  assign t_idx      = si_q + sj_q;
  // the lookup was issued in the same cycle as the write of S[j]: forward it
  assign ks         = (t_idx == j_q) ? si_q : perm_rdata;
  assign out_load   = (state_q == ST_P_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    si_d     = si_q;
    sj_d     = sj_q;
    byte_d   = byte_q;
    k_d      = k_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    kidx_d   = kidx_q;
    key_we   = 1'b0;
    perm_req = '{clr: 1'b0, we: 1'b0, waddr: k_q, wdata: si_q, raddr: k_q};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ActData) begin
            i_d            = i_q + 8'd1;
            perm_req.raddr = i_d;
            byte_d         = in_byte_i;
            state_d        = ST_P_J;
          end else begin
            key_we = key_room;
            cnt_d  = cnt_new;
            if (key_end_i) begin
              // restart from the identity and schedule over the stored key
              len_d        = cnt_new;
              cnt_d        = '0;
              perm_req.clr = 1'b1;
              k_d          = '0;
              kidx_d       = '0;
              acc_d        = '0;
              state_d      = ST_K_RD;
            end
          end
        end
      end
      ST_P_J: begin
        si_d           = perm_rdata;
        j_d            = j_q + perm_rdata;
        perm_req.raddr = j_d;
        state_d        = ST_P_WI;
      end
      ST_P_WI: begin
        sj_d           = perm_rdata;
        perm_req.we    = 1'b1;
        perm_req.waddr = i_q;
        perm_req.wdata = perm_rdata;
        state_d        = ST_P_WJ;
      end
      ST_P_WJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_q;
        perm_req.wdata = si_q;
        perm_req.raddr = t_idx;
        state_d        = ST_P_OUT;
      end
      ST_P_OUT: begin
        perm_req.raddr = t_idx;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_K_RD: begin
        perm_req.raddr = k_q;
        state_d        = ST_K_ACC;
      end
      ST_K_ACC: begin
        si_d           = perm_rdata;
        acc_d          = acc_q + perm_rdata + key_rdata;
        perm_req.raddr = acc_d;
        state_d        = ST_K_W1;
      end
      ST_K_W1: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = k_q;
        perm_req.wdata = perm_rdata;
        state_d        = ST_K_W2;
      end
      ST_K_W2: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = acc_q;
        perm_req.wdata = si_q;
        k_d            = k_q + 8'd1;
        if (CntW'(kidx_q) + CntW'(1) == len_q) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KeyW'(1);
        end
        if (k_q == LastIdx) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_K_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    byte_q <= byte_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    len_q  <= len_d;
    kidx_q <= kidx_d;
    if (out_load) begin
      out_byte_q    <= byte_q ^ ks;
      stream_byte_q <= ks;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign stream_byte_o = stream_byte_q;

  a_data_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ActData) |-> ##4 (state_q == ST_P_OUT))
    else $error("data item did not reach the output step on time");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ActKey && !key_end_i)
      |=> (cnt_q <= CntW'(KEY_DEPTH)))
    else $error("key count beyond key depth");

  a_kidx_in_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K_RD) |-> (CntW'(kidx_q) < len_q))
    else $error("key index outside stored key");

  a_ksa_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K_W2 && k_q == LastIdx)
      |=> (state_q == ST_IDLE && i_q == '0 && j_q == '0 && cnt_q == '0))
    else $error("key schedule did not finish cleanly");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_P_OUT))
    else $error("result dropped while receiver stalls");

endmodule

`default_nettype wire

>>> rtl/core/rc4_perm_mem.sv
`default_nettype none

module rc4_perm_mem import rc4_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  perm_req_t req_i,
  output byte_t     rdata_o
);

  byte_t                mem [PermDepth];
  logic [PermDepth-1:0] vld_q;
  byte_t                rdata_q;
  byte_t                raddr_q;
  logic                 rvld_q;

  // an entry never written since the last clear holds its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[req_i.raddr];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
    raddr_q <= req_i.raddr;
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  assign rdata_o = rvld_q ? rdata_q : raddr_q;

endmodule

`default_nettype wire

>>> rtl/core/rc4_key_mem.sv
`default_nettype none

module rc4_key_mem import rc4_pkg::*; #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire  [AddrW-1:0] waddr_i,
  input  byte_t            wdata_i,
  input  wire  [AddrW-1:0] raddr_i,
  output byte_t            rdata_o
);

  byte_t mem [Depth];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
